// File: rtl/bblur_pkg.sv
// shared types, constants and helper functions for the 3x3 box blur
`default_nettype none

package bblur_pkg;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // configuration port
    localparam int CFG_DATA_W  = 13;
    localparam int FRAME_W_W   = 11;
    localparam int FRAME_H_W   = 13;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // queue between classifier and datapath
    localparam int QUEUE_DEPTH = 4;

    // datapath widths
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    typedef struct packed {
        logic                is_flush;
        logic [CHAN_W-1:0]   red_in;
        logic [CHAN_W-1:0]   green_in;
        logic [CHAN_W-1:0]   blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]   red_out;
        logic [CHAN_W-1:0]   green_out;
        logic [CHAN_W-1:0]   blue_out;
        logic                frame_end;
    } t_out_item;

    typedef struct packed {
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
    } t_pix;

    // classified item handed from the front to the datapath
    typedef struct packed {
        t_pix        pix;
        logic        has_out;
        logic        frame_end;
        logic [2:0]  row_mask;
        logic [2:0]  col_mask;
    } t_work;

    // zero reads as one, large values saturate
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        int unsigned res;
        if (v == 0) begin
            res = 1;
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // number of in-frame window pixels
    function automatic logic [CNT_W-1:0] mask_count(input logic [2:0] rm, input logic [2:0] cm);
        logic [1:0]       nr;
        logic [1:0]       nc;
        logic [CNT_W-1:0] n;
        nr = 2'(rm[0]) + 2'(rm[1]) + 2'(rm[2]);
        nc = 2'(cm[0]) + 2'(cm[1]) + 2'(cm[2]);
        n  = CNT_W'(nr) * CNT_W'(nc);
        if (n == '0) begin
            n = CNT_W'(1);
        end
        return n;
    endfunction

    // ceil(2^RECIP_SHIFT / n) for the divisors that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            CNT_W'(2): m = RECIP_W'(524288);
            CNT_W'(3): m = RECIP_W'(349526);
            CNT_W'(4): m = RECIP_W'(262144);
            CNT_W'(6): m = RECIP_W'(174763);
            CNT_W'(9): m = RECIP_W'(116509);
            default:   m = RECIP_W'(1048576);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bblur_fifo.sv
// short queue between the classifier and the blur datapath
`default_nettype none

module bblur_fifo #(
    parameter int DEPTH = bblur_pkg::QUEUE_DEPTH,
    parameter int DW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [DW-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count,  n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bblur_front.sv
// frame position tracking and classification of incoming items
`default_nettype none

module bblur_front #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire bblur_pkg::t_cfg_reg                 i_cfg_index,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire bblur_pkg::t_in_item                 i_in_data,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output bblur_pkg::t_work                         o_work,
    output logic [CW-1:0]                            o_addr
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int unsigned RST_W = bblur_pkg::clamp_dim(bblur_pkg::RESET_WIDTH, MAX_WIDTH);
    localparam int unsigned RST_H = bblur_pkg::clamp_dim(bblur_pkg::RESET_HEIGHT, MAX_HEIGHT);

    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic          accept;
    logic          col_zero;
    logic [WW-1:0] col_next;
    logic          wrap;
    logic [CW-1:0] w_last;
    logic [CW-1:0] ocol;
    logic [RW-1:0] orow;
    logic [RW-1:0] h_ext;
    logic          has_out;
    logic          frame_end;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept;
    assign o_addr     = r_col;

    // output coordinates and neighbourhood masks for the current position
    always_comb begin
        col_zero  = (r_col == '0);
        col_next  = WW'(r_col) + WW'(1);
        wrap      = (col_next >= r_w);
        w_last    = CW'(r_w - WW'(1));
        h_ext     = RW'(r_h);
        ocol      = col_zero ? w_last : r_col - CW'(1);
        has_out   = col_zero ? (r_row >= RW'(2)) : (r_row >= RW'(1));
        orow      = col_zero ? r_row - RW'(2) : r_row - RW'(1);
        frame_end = has_out && (orow >= h_ext - RW'(1)) && (ocol == w_last);

        o_work.pix       = i_in_data.is_flush ? '0 :
                           {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        o_work.has_out   = has_out;
        o_work.frame_end = frame_end;
        o_work.row_mask[0] = (orow != '0) && (orow <= h_ext);
        o_work.row_mask[1] = (orow < h_ext);
        o_work.row_mask[2] = ((orow + RW'(1)) < h_ext);
        o_work.col_mask[0] = (ocol != '0);
        o_work.col_mask[1] = (WW'(ocol) < r_w);
        o_work.col_mask[2] = ((WW'(ocol) + WW'(1)) < r_w);
    end

    // next position: restart on register write or frame end
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (wrap) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = CW'(col_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // frame size registers, kept clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(RST_W);
            r_h <= HW'(RST_H);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bblur_pkg::CFG_FRAME_WIDTH: begin
                    r_w <= WW'(bblur_pkg::clamp_dim(
                        32'(i_cfg_data[bblur_pkg::FRAME_W_W-1:0]), MAX_WIDTH));
                end
                bblur_pkg::CFG_FRAME_HEIGHT: begin
                    r_h <= HW'(bblur_pkg::clamp_dim(
                        32'(i_cfg_data[bblur_pkg::FRAME_H_W-1:0]), MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/bblur_back.sv
// line stores, 3x3 window, masked sums and rounded mean
`default_nettype none

module bblur_back #(
    parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_pop,
    input  wire bblur_pkg::t_work  i_work,
    input  wire logic [CW-1:0]     i_addr,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bblur_pkg::t_out_item   o_out_data
);

    localparam int PIX_W  = $bits(bblur_pkg::t_pix);
    localparam int LINE_W = 2 * PIX_W;
    localparam int SUM_W  = bblur_pkg::SUM_W;
    localparam int CNT_W  = bblur_pkg::CNT_W;
    localparam int PROD_W = SUM_W + bblur_pkg::RECIP_W;

    // both line stores share one address: upper half is two rows back
    logic [LINE_W-1:0]   r_line [MAX_WIDTH];
    logic [LINE_W-1:0]   r_rd;
    logic                r_fwd_hit;
    logic [LINE_W-1:0]   r_fwd_data;

    logic                adv;
    logic                pop;
    logic                a_wr;
    logic [LINE_W-1:0]   a_line;
    bblur_pkg::t_pix     a_up;
    bblur_pkg::t_pix     a_lo;

    logic                r_a_valid;
    bblur_pkg::t_work    r_a_work;
    logic [CW-1:0]       r_a_addr;

    bblur_pkg::t_pix     r_win [3][3];

    logic                r_b_valid;
    logic                r_b_has_out;
    logic                r_b_frame_end;
    logic [2:0]          r_b_row_mask;
    logic [2:0]          r_b_col_mask;
    logic [SUM_W-1:0]    b_sum_r, b_sum_g, b_sum_b;

    logic                r_c_valid;
    logic                r_c_has_out;
    logic                r_c_frame_end;
    logic [SUM_W-1:0]    r_c_sum_r, r_c_sum_g, r_c_sum_b;
    logic [CNT_W-1:0]    r_c_count;
    logic [bblur_pkg::RECIP_W-1:0] c_recip;
    logic [PROD_W-1:0]   c_prod_r, c_prod_g, c_prod_b;

    logic                r_out_valid;
    bblur_pkg::t_out_item r_out_data;

    // whole datapath moves when the output register can take a result
    assign adv  = !r_out_valid || i_out_ready;
    assign pop  = adv && i_valid;
    assign a_wr = adv && r_a_valid;
    assign o_pop = pop;

    // read data, with bypass of the write landing on the same edge
    assign a_line = r_fwd_hit ? r_fwd_data : r_rd;
    assign a_up   = a_line[LINE_W-1:PIX_W];
    assign a_lo   = a_line[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (a_wr) begin
            r_line[r_a_addr] <= {a_lo, r_a_work.pix};
        end
        if (pop) begin
            r_rd <= r_line[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_fwd_hit  <= r_a_valid && (i_addr == r_a_addr);
            r_fwd_data <= {a_lo, r_a_work.pix};
        end
    end

    // stage a: item waiting on its line store read
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_work <= i_work;
            r_a_addr <= i_addr;
        end
    end

    // window shift, newest column on the right
    always_ff @(posedge i_clk) begin
        if (a_wr) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= a_up;
            r_win[1][2] <= a_lo;
            r_win[2][2] <= r_a_work.pix;
        end
    end

    // stage b: masked window sums
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_has_out   <= r_a_work.has_out;
            r_b_frame_end <= r_a_work.frame_end;
            r_b_row_mask  <= r_a_work.row_mask;
            r_b_col_mask  <= r_a_work.col_mask;
        end
    end

    always_comb begin
        b_sum_r = '0;
        b_sum_g = '0;
        b_sum_b = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_b_row_mask[i] && r_b_col_mask[j]) begin
                    b_sum_r = b_sum_r + SUM_W'(r_win[i][j].red);
                    b_sum_g = b_sum_g + SUM_W'(r_win[i][j].green);
                    b_sum_b = b_sum_b + SUM_W'(r_win[i][j].blue);
                end
            end
        end
    end

    // stage c: rounded mean by reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_has_out   <= r_b_has_out;
            r_c_frame_end <= r_b_frame_end;
            r_c_sum_r     <= b_sum_r;
            r_c_sum_g     <= b_sum_g;
            r_c_sum_b     <= b_sum_b;
            r_c_count     <= bblur_pkg::mask_count(r_b_row_mask, r_b_col_mask);
        end
    end

    always_comb begin
        c_recip  = bblur_pkg::recip(r_c_count);
        c_prod_r = PROD_W'(r_c_sum_r + SUM_W'(r_c_count >> 1)) * PROD_W'(c_recip);
        c_prod_g = PROD_W'(r_c_sum_g + SUM_W'(r_c_count >> 1)) * PROD_W'(c_recip);
        c_prod_b = PROD_W'(r_c_sum_b + SUM_W'(r_c_count >> 1)) * PROD_W'(c_recip);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data.red_out   <= c_prod_r[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CHAN_W];
            r_out_data.green_out <= c_prod_g[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CHAN_W];
            r_out_data.blue_out  <= c_prod_b[bblur_pkg::RECIP_SHIFT +: bblur_pkg::CHAN_W];
            r_out_data.frame_end <= r_c_frame_end;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid && r_c_has_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: rtl/box_blur_three_by_three.sv
// top level of the streaming 3x3 rgb box blur
//
// input channel: one rgb pixel per transfer in raster order, or a flush
// item; after the last pixel of a frame the source sends width+1 flush
// items so that the final results drain. output channel: one blurred
// pixel per transfer, frame_end set on the last pixel of the frame.
// configuration: frame width (index 0) and height (index 1), written
// while the block is idle; a write also restarts the frame position.
// the result for pixel (r,c) is produced by the item arriving one row
// plus one pixel later and reaches the output after that item has
// passed the queue, line store read, window sum and divide. sustained
// throughput is one item per cycle while the receiver keeps ready;
// the single-port-per-side line store memory takes one read and one
// write each cycle. reset clears position, queue and pipeline flags and
// loads 640x480; line stores are not cleared, their unwritten entries
// always fall outside the frame. if the receiver stalls the datapath
// holds, the queue fills and then the input ready drops.
`default_nettype none

module box_blur_three_by_three #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire bblur_pkg::t_cfg_reg              i_cfg_index,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire bblur_pkg::t_in_item              i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output bblur_pkg::t_out_item                  o_out_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WK = $bits(bblur_pkg::t_work);
    localparam int DW = WK + CW;

    logic             push;
    logic             full;
    bblur_pkg::t_work f_work;
    logic [CW-1:0]    f_addr;
    logic             q_valid;
    logic             q_pop;
    logic [DW-1:0]    q_data;

    // classifier
    bblur_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_full      (full),
        .o_push      (push),
        .o_work      (f_work),
        .o_addr      (f_addr)
    );

    // decoupling queue
    bblur_fifo #(
        .DEPTH (bblur_pkg::QUEUE_DEPTH),
        .DW    (DW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_addr, f_work}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // blur datapath
    bblur_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_work      (bblur_pkg::t_work'(q_data[WK-1:0])),
        .i_addr      (q_data[DW-1 -: CW]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_box_blur_three_by_three.sv
// self-checking testbench for the streaming 3x3 rgb box blur
`default_nettype none

module tb_box_blur_three_by_three;

    import bblur_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int SMALL_ITEMS   = 1250;

    typedef enum logic {
        ROW_CONFIG,
        ROW_ITEM
    } row_kind_e;

    // one line of the directed table
    typedef struct packed {
        row_kind_e                 kind;
        t_cfg_reg                  reg_sel;
        logic [CFG_DATA_W-1:0]     cfg_val;
        t_in_item                  item;
        logic                      typed;
        t_out_item                 result;
    } stim_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_reg              cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;

    // idling control and run bookkeeping
    int  send_idle_pct   = 20;
    int  recv_idle_pct   = 86;
    logic settling       = 1'b0;
    int  cycles          = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  frames_closed   = 0;
    int  mismatches      = 0;

    // blurred pixels still owed by the block, oldest first
    t_out_item blurred_due[$];
    t_out_item due_pixel;

    // mirror of the blur state
    t_pix      upper_line [MAX_WIDTH_DEF];
    t_pix      lower_line [MAX_WIDTH_DEF];
    t_pix      win [3][3];
    int        col_pos;
    int        row_pos;
    logic [FRAME_W_W-1:0] width_reg;
    logic [FRAME_H_W-1:0] height_reg;
    int        eff_width;
    int        eff_height;

    stim_row_t directed_rows [28];

    box_blur_three_by_three dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // cycle count and watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     blurred_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver back-pressure, always ready while settling
    always @(posedge clk) begin
        out_ready <= settling ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at cycle %0d: expected %02h %02h %02h end %0b,",
                     what, cycles, want.red_out, want.green_out, want.blue_out,
                     want.frame_end);
            $display("    got %02h %02h %02h end %0b", got.red_out, got.green_out,
                     got.blue_out, got.frame_end);
        end
    endtask

    // output checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (blurred_due.size() == 0) begin
                note_mismatch("nothing due", '0, out_data);
            end else begin
                due_pixel = blurred_due.pop_front();
                results_checked++;
                if (out_data.red_out !== due_pixel.red_out ||
                    out_data.green_out !== due_pixel.green_out ||
                    out_data.blue_out !== due_pixel.blue_out ||
                    out_data.frame_end !== due_pixel.frame_end) begin
                    note_mismatch("field", due_pixel, out_data);
                end
            end
            if (out_data.frame_end === 1'b1) begin
                frames_closed++;
            end
        end
    end

    // recompute effective frame size from the register values
    function automatic void refresh_dims();
        eff_width  = (width_reg == 0) ? 1 :
                     ((int'(width_reg) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg));
        eff_height = (height_reg == 0) ? 1 :
                     ((int'(height_reg) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_reg));
    endfunction

    // advance the blur state by one item, returns 1 when a pixel comes out
    function automatic bit box_mean_step(input t_in_item item, output t_out_item res);
        t_pix        pix;
        t_pix        up;
        t_pix        lo;
        int          c;
        int          r;
        int          orow;
        int          ocol;
        int          rr;
        int          cc;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int unsigned cnt;
        res = '0;
        pix = item.is_flush ? t_pix'('0) : t_pix'({item.red_in, item.green_in, item.blue_in});
        c = col_pos;
        r = row_pos;
        up = upper_line[c];
        lo = lower_line[c];
        upper_line[c] = lo;
        lower_line[c] = pix;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = pix;
        // output position trails the input by one row plus one pixel
        if (c >= 1) begin
            ocol = c - 1;
            orow = r - 1;
        end else begin
            ocol = eff_width - 1;
            orow = r - 2;
        end
        c++;
        if (c >= eff_width) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        if (orow < 0) begin
            return 1'b0;
        end
        // sum only the in-frame neighbours
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt   = 0;
        for (int i = 0; i < 3; i++) begin
            rr = orow - 1 + i;
            if (rr < 0 || rr >= eff_height) continue;
            for (int j = 0; j < 3; j++) begin
                cc = ocol - 1 + j;
                if (cc < 0 || cc >= eff_width) continue;
                sum_r += win[i][j].red;
                sum_g += win[i][j].green;
                sum_b += win[i][j].blue;
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        // mean rounded half up
        res.red_out   = 8'((2 * sum_r + cnt) / (2 * cnt));
        res.green_out = 8'((2 * sum_g + cnt) / (2 * cnt));
        res.blue_out  = 8'((2 * sum_b + cnt) / (2 * cnt));
        if (orow >= eff_height - 1 && ocol == eff_width - 1) begin
            res.frame_end = 1'b1;
            col_pos = 0;
            row_pos = 0;
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t cfg_row(input t_cfg_reg sel,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.kind    = ROW_CONFIG;
        row.reg_sel = sel;
        row.cfg_val = val;
        return row;
    endfunction

    function automatic stim_row_t item_row(input logic flush, input logic [23:0] rgb);
        stim_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item = t_in_item'({flush, rgb});
        return row;
    endfunction

    function automatic stim_row_t checked_row(input logic flush, input logic [23:0] rgb,
                                              input logic [23:0] want, input logic fe);
        stim_row_t row;
        row = item_row(flush, rgb);
        row.typed  = 1'b1;
        row.result = t_out_item'({want, fe});
        return row;
    endfunction

    function automatic t_in_item random_item(input logic flush);
        t_in_item item;
        item.is_flush = flush;
        item.red_in   = 8'($urandom_range(255));
        item.green_in = 8'($urandom_range(255));
        item.blue_in  = 8'($urandom_range(255));
        return item;
    endfunction

    // drop valid and wait for every owed result, then let the pipeline empty
    task automatic quiesce();
        in_valid <= 1'b0;
        do @(posedge clk); while (blurred_due.size() != 0);
        settling <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        settling <= 1'b0;
    endtask

    task automatic write_frame_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] val);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_FRAME_WIDTH) begin
            width_reg = val[FRAME_W_W-1:0];
        end else begin
            height_reg = val[FRAME_H_W-1:0];
        end
        refresh_dims();
        // a write restarts the frame
        col_pos = 0;
        row_pos = 0;
    endtask

    // one input transfer, with random gaps and the odd full pause
    task automatic send_pixel_item(input t_in_item item, input bit typed,
                                   input t_out_item typed_res);
        t_out_item res;
        bit        produced;
        if ($urandom_range(299) == 0) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (blurred_due.size() != 0);
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        produced = box_mean_step(item, res);
        if (typed) res = typed_res;
        if (produced || typed) blurred_due.push_back(res);
        items_sent++;
    endtask

    // well-formed frame: pixels with rare holes, then the drain items
    task automatic stream_frame();
        for (int n = 0; n < eff_width * eff_height; n++) begin
            send_pixel_item(random_item($urandom_range(99) < 3), 1'b0, '0);
        end
        for (int n = 0; n <= eff_width; n++) begin
            send_pixel_item(random_item($urandom_range(4) != 0), 1'b0, '0);
        end
    endtask

    // broken sequence, usually cut short by the next register write
    task automatic stream_noise(input int count);
        for (int n = 0; n < count; n++) begin
            send_pixel_item(random_item($urandom_range(9) < 3), 1'b0, '0);
        end
    endtask

    initial begin
        int                    phase;
        int                    base;
        int                    small_items;
        int                    frames;
        logic [CFG_DATA_W-1:0] wval;
        logic [CFG_DATA_W-1:0] hval;

        // predictor reset state
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = FRAME_W_W'(RESET_WIDTH);
        height_reg = FRAME_H_W'(RESET_HEIGHT);
        refresh_dims();

        // directed table: pass-through on one-pixel frames, flush and drain
        // cases, zero register values, and half-up rounding on a 2x2 frame
        directed_rows = '{
            cfg_row(CFG_FRAME_WIDTH, 13'd1),
            cfg_row(CFG_FRAME_HEIGHT, 13'd1),
            item_row(1'b0, 24'hFF00FF),
            item_row(1'b1, 24'hAA55AA),
            checked_row(1'b1, 24'h55AA55, 24'hFF00FF, 1'b1),
            item_row(1'b0, 24'h00FF00),
            item_row(1'b1, 24'h000000),
            checked_row(1'b1, 24'hFFFFFF, 24'h00FF00, 1'b1),
            item_row(1'b0, 24'h807F01),
            item_row(1'b0, 24'hAA55AA),
            checked_row(1'b1, 24'h000000, 24'h807F01, 1'b1),
            item_row(1'b1, 24'h123456),
            item_row(1'b1, 24'h000000),
            checked_row(1'b1, 24'h000000, 24'h000000, 1'b1),
            cfg_row(CFG_FRAME_WIDTH, 13'd0),
            cfg_row(CFG_FRAME_HEIGHT, 13'd0),
            item_row(1'b0, 24'h123456),
            item_row(1'b1, 24'h000000),
            checked_row(1'b1, 24'h000000, 24'h123456, 1'b1),
            cfg_row(CFG_FRAME_WIDTH, 13'd2),
            cfg_row(CFG_FRAME_HEIGHT, 13'd2),
            item_row(1'b0, 24'hFF0001),
            item_row(1'b0, 24'hFF0001),
            item_row(1'b0, 24'hFF0002),
            checked_row(1'b0, 24'hFF0002, 24'hFF0002, 1'b0),
            checked_row(1'b1, 24'h000000, 24'hFF0002, 1'b0),
            checked_row(1'b1, 24'h000000, 24'hFF0002, 1'b0),
            checked_row(1'b1, 24'h000000, 24'hFF0002, 1'b1)
        };

        // synchronous reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CONFIG) begin
                write_frame_reg(directed_rows[k].reg_sel, directed_rows[k].cfg_val);
            end else begin
                send_pixel_item(directed_rows[k].item, directed_rows[k].typed,
                                directed_rows[k].result);
            end
        end

        // random phases of frame settings and streams
        phase       = 0;
        small_items = 0;
        while (small_items < SMALL_ITEMS) begin
            if (small_items < SMALL_ITEMS / 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 86;
            end else if (small_items < 2 * SMALL_ITEMS / 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            base = items_sent;
            case (phase)
                // widest frame, register value saturating to the store depth,
                // restarted within the first rows
                2: begin
                    write_frame_reg(CFG_FRAME_WIDTH, 13'd2047);
                    write_frame_reg(CFG_FRAME_HEIGHT, 13'd1);
                    stream_noise(60);
                end
                // tallest frame, register value saturating, one column,
                // restarted within the first rows
                5: begin
                    write_frame_reg(CFG_FRAME_WIDTH, 13'd1);
                    write_frame_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
                    stream_noise(60);
                end
                // exact limits, restarted part way through the first row
                8: begin
                    write_frame_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH_DEF));
                    write_frame_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(MAX_HEIGHT_DEF));
                    stream_noise(40);
                end
                default: begin
                    case ($urandom_range(9))
                        0:       wval = '0;
                        1:       wval = 13'd1;
                        2:       wval = CFG_DATA_W'($urandom_range(9, 24));
                        default: wval = CFG_DATA_W'($urandom_range(1, 8));
                    endcase
                    // upper data bits lie outside the width register
                    if ($urandom_range(3) == 0) begin
                        wval[CFG_DATA_W-1:FRAME_W_W] = 2'($urandom_range(1, 3));
                    end
                    case ($urandom_range(9))
                        0:       hval = '0;
                        1:       hval = 13'd1;
                        2:       hval = CFG_DATA_W'($urandom_range(9, 16));
                        default: hval = CFG_DATA_W'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(3))
                        0:       write_frame_reg(CFG_FRAME_WIDTH, wval);
                        1:       write_frame_reg(CFG_FRAME_HEIGHT, hval);
                        default: begin
                            write_frame_reg(CFG_FRAME_WIDTH, wval);
                            write_frame_reg(CFG_FRAME_HEIGHT, hval);
                        end
                    endcase
                    frames = $urandom_range(1, 3);
                    repeat (frames) stream_frame();
                    if ($urandom_range(3) == 0) begin
                        stream_noise($urandom_range(1, eff_width * eff_height + eff_width));
                    end
                end
            endcase
            small_items += items_sent - base;
            phase++;
        end

        quiesce();
        $display("run covered %0d input transfers, %0d blurred pixels checked, %0d frames",
                 items_sent, results_checked, frames_closed);
        $display("one-pixel to saturated frame sizes, mid-frame restarts, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
